[design/masked_word_and_string_search_defines.svh]
// assertion macros shared by the checker
`ifndef MASKED_WORD_AND_STRING_SEARCH_DEFINES_SVH
`define MASKED_WORD_AND_STRING_SEARCH_DEFINES_SVH

// clocked assertion, switched off while reset is high
`define MWSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked through reset
`define MWSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/mwss_pkg.sv]
`timescale 1ns / 1ps

package mwss_pkg;

   localparam int MAX_PATTERN_BYTES = 16;
   localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int ADDR_W            = 32;
   localparam int WORD_W            = 32;
   localparam int WORD_BYTES        = 4;
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_ADDR_W        = 6;
   localparam int CSR_LANE_BITS     = 3;

   localparam logic [ADDR_W-1:0] PAGE_MASK       = ~ADDR_W'(32'hfff);
   localparam logic [ADDR_W-1:0] PAGE_NONE       = '1;
   localparam logic [WORD_W-1:0] WORD_MASK_RESET = '1;
   localparam logic [LEN_W-1:0]  PATTERN_LEN_RESET = LEN_W'(1);

   typedef logic [7:0] byte_type;

   typedef enum logic {
      MODE_WORD   = 1'b0,
      MODE_STRING = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      REG_SEARCH_MODE  = 3'd0,
      REG_WORD_VALUE   = 3'd1,
      REG_WORD_MASK    = 3'd2,
      REG_PATTERN_LOW  = 3'd3,
      REG_PATTERN_HIGH = 3'd4,
      REG_PATTERN_LEN  = 3'd5
   } reg_index_type;

   // configuration as seen by the match logic
   typedef struct packed {
      mode_type                          search_mode;
      logic [WORD_W-1:0]                 word_value;
      logic [WORD_W-1:0]                 word_mask;
      byte_type [MAX_PATTERN_BYTES-1:0]  pattern;
      logic [LEN_W-1:0]                  pattern_len;
   } cfg_type;

   // input register contents, entry 0 of the window is the newest byte
   typedef struct packed {
      logic                              valid;
      byte_type [MAX_PATTERN_BYTES-1:0]  window;
      logic [LEN_W-1:0]                  fill;
      logic [ADDR_W-1:0]                 addr;
   } stage_type;

endpackage

[design/mwss_if.sv]
`timescale 1ns / 1ps

interface mwss_req_if;
   logic                valid;
   logic                ready;
   mwss_pkg::byte_type  data_byte;
   logic                first_of_image;

   modport source (output valid, output data_byte, output first_of_image, input ready);
   modport sink (input valid, input data_byte, input first_of_image, output ready);
endinterface

interface mwss_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mwss_pkg::ADDR_W-1:0] match_address;
   logic                        new_page;

   modport source (output valid, output match_address, output new_page, input ready);
   modport sink (input valid, input match_address, input new_page, output ready);
endinterface

[design/masked_word_and_string_search.sv]
// Masked word and byte string search over a memory image streamed one byte
// per transaction. Each accepted byte is shifted into a 16-byte window held
// in the input register; the window is compared against the search word or
// the string pattern in a single pass and any hit lands in the result
// register as the window holding its last byte moves on. One byte is accepted
// every clock cycle, limited only by that one-deep window stage and the
// result register: the input stalls only while a hit sits unclaimed in the
// result register with another item waiting behind it. first_of_image
// restarts the address at zero and empties the window; the page of the last
// hit survives it and is cleared only by reset. No clearing pass is needed
// after reset. Configuration registers sit at byte address 8*i, 64 bits wide,
// and are to be written only while the block is idle.
`timescale 1ns / 1ps

module masked_word_and_string_search (
   input  logic                                clock,
   input  logic                                reset,
   mwss_req_if.sink                            req_ch,
   mwss_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mwss_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mwss_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mwss_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   // configuration snapshot shared with the compare logic
   mwss_pkg::cfg_type    cfg;
   // window stage contents handed to the compare logic
   mwss_pkg::stage_type  stage;
   // window stage may move on: result register empty or being drained
   logic                 advance;

   // apb register file
   mwss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register: byte window, fill level and address counter
   mwss_window u_window (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .advance (advance),
      .stage   (stage)
   );

   // word / string compare, page tracking and result register
   mwss_match u_match (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .stage   (stage),
      .rsp_ch  (rsp_ch),
      .advance (advance)
   );

endmodule

[design/mwss_csr.sv]
`timescale 1ns / 1ps

module mwss_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mwss_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mwss_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mwss_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output mwss_pkg::cfg_type                   cfg
);

   mwss_pkg::mode_type                 mode_ff;
   logic [mwss_pkg::WORD_W-1:0]        value_ff;
   logic [mwss_pkg::WORD_W-1:0]        mask_ff;
   logic [mwss_pkg::CSR_DATA_W-1:0]    pat_lo_ff;
   logic [mwss_pkg::CSR_DATA_W-1:0]    pat_hi_ff;
   logic [mwss_pkg::LEN_W-1:0]         len_ff;
   logic                               write_en;
   mwss_pkg::reg_index_type            index;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready;
   assign index    = mwss_pkg::reg_index_type'(
                        paddr[mwss_pkg::CSR_ADDR_W-1:mwss_pkg::CSR_LANE_BITS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= mwss_pkg::MODE_WORD;
         value_ff  <= '0;
         mask_ff   <= mwss_pkg::WORD_MASK_RESET;
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         len_ff    <= mwss_pkg::PATTERN_LEN_RESET;
      end else if (write_en) begin
         case (index)
            mwss_pkg::REG_SEARCH_MODE: begin
               mode_ff <= mwss_pkg::mode_type'(pwdata[0]);
            end
            mwss_pkg::REG_WORD_VALUE: begin
               value_ff <= pwdata[mwss_pkg::WORD_W-1:0];
            end
            mwss_pkg::REG_WORD_MASK: begin
               mask_ff <= pwdata[mwss_pkg::WORD_W-1:0];
            end
            mwss_pkg::REG_PATTERN_LOW: begin
               pat_lo_ff <= pwdata;
            end
            mwss_pkg::REG_PATTERN_HIGH: begin
               pat_hi_ff <= pwdata;
            end
            mwss_pkg::REG_PATTERN_LEN: begin
               len_ff <= pwdata[mwss_pkg::LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         mwss_pkg::REG_SEARCH_MODE:  prdata = mwss_pkg::CSR_DATA_W'(mode_ff);
         mwss_pkg::REG_WORD_VALUE:   prdata = mwss_pkg::CSR_DATA_W'(value_ff);
         mwss_pkg::REG_WORD_MASK:    prdata = mwss_pkg::CSR_DATA_W'(mask_ff);
         mwss_pkg::REG_PATTERN_LOW:  prdata = pat_lo_ff;
         mwss_pkg::REG_PATTERN_HIGH: prdata = pat_hi_ff;
         mwss_pkg::REG_PATTERN_LEN:  prdata = mwss_pkg::CSR_DATA_W'(len_ff);
         default:                    prdata = '0;
      endcase
   end

   always_comb begin
      cfg.search_mode = mode_ff;
      cfg.word_value  = value_ff;
      cfg.word_mask   = mask_ff;
      cfg.pattern     = {pat_hi_ff, pat_lo_ff};
      cfg.pattern_len = len_ff;
   end

endmodule

[design/mwss_window.sv]
`timescale 1ns / 1ps

module mwss_window (
   input  logic                  clock,
   input  logic                  reset,
   mwss_req_if.sink              req_ch,
   input  logic                  advance,
   output mwss_pkg::stage_type   stage
);

   localparam int MAXB = mwss_pkg::MAX_PATTERN_BYTES;

   logic                                    valid_ff, valid_in;
   mwss_pkg::byte_type [MAXB-1:0]           window_ff, window_in;
   logic [mwss_pkg::LEN_W-1:0]              fill_ff, fill_in;
   logic [mwss_pkg::ADDR_W-1:0]             addr_ff, addr_in;
   logic [mwss_pkg::ADDR_W-1:0]             pos_ff, pos_in;
   logic                                    accept;

   assign req_ch.ready = !valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in  = valid_ff;
      window_in = window_ff;
      fill_in   = fill_ff;
      addr_in   = addr_ff;
      pos_in    = pos_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         if (req_ch.first_of_image) begin
            // new image: empty window, address back to zero
            window_in    = '0;
            window_in[0] = req_ch.data_byte;
            fill_in      = mwss_pkg::LEN_W'(1);
            addr_in      = '0;
            pos_in       = mwss_pkg::ADDR_W'(1);
         end else begin
            window_in = {window_ff[MAXB-2:0], req_ch.data_byte};
            if (fill_ff < mwss_pkg::LEN_W'(MAXB)) begin
               fill_in = fill_ff + 1'b1;
            end
            addr_in = pos_ff;
            pos_in  = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         window_ff <= '0;
         fill_ff   <= '0;
         addr_ff   <= '0;
         pos_ff    <= '0;
      end else begin
         valid_ff  <= valid_in;
         window_ff <= window_in;
         fill_ff   <= fill_in;
         addr_ff   <= addr_in;
         pos_ff    <= pos_in;
      end
   end

   always_comb begin
      stage.valid  = valid_ff;
      stage.window = window_ff;
      stage.fill   = fill_ff;
      stage.addr   = addr_ff;
   end

endmodule

[design/mwss_match.sv]
`timescale 1ns / 1ps

module mwss_match (
   input  logic                  clock,
   input  logic                  reset,
   input  mwss_pkg::cfg_type     cfg,
   input  mwss_pkg::stage_type   stage,
   mwss_rsp_if.source            rsp_ch,
   output logic                  advance
);

   localparam int MAXB = mwss_pkg::MAX_PATTERN_BYTES;
   localparam int AW   = mwss_pkg::ADDR_W;

   logic                        out_valid_ff, out_valid_in;
   logic [AW-1:0]               out_addr_ff, out_addr_in;
   logic                        out_new_ff, out_new_in;
   logic [AW-1:0]               prev_page_ff, prev_page_in;

   logic [mwss_pkg::LEN_W-1:0]  len_eff;
   logic [MAXB:0]               len_hit;
   logic [mwss_pkg::WORD_W-1:0] word;
   logic                        word_hit;
   logic                        string_hit;
   logic                        hit;
   logic [AW-1:0]               start;
   logic [AW-1:0]               page;

   assign advance = !out_valid_ff || rsp_ch.ready;

   // lengths above the window depth act as the full window
   assign len_eff = (cfg.pattern_len > mwss_pkg::LEN_W'(MAXB)) ?
                    mwss_pkg::LEN_W'(MAXB) : cfg.pattern_len;

   // pattern compare for every possible length in parallel
   always_comb begin
      len_hit = '0;
      for (int l = 1; l <= MAXB; l++) begin
         len_hit[l] = 1'b1;
         for (int k = 0; k < l; k++) begin
            if (stage.window[l-1-k] != cfg.pattern[k]) begin
               len_hit[l] = 1'b0;
            end
         end
      end
   end

   assign string_hit = (len_eff != '0) && (stage.fill >= len_eff) && len_hit[len_eff];

   assign word     = {stage.window[0], stage.window[1], stage.window[2], stage.window[3]};
   assign word_hit = (stage.fill >= mwss_pkg::LEN_W'(mwss_pkg::WORD_BYTES))
                     && (stage.window[mwss_pkg::WORD_BYTES-1] == cfg.word_value[7:0])
                     && ((word & cfg.word_mask) == cfg.word_value);

   always_comb begin
      case (cfg.search_mode)
         mwss_pkg::MODE_WORD: begin
            hit   = stage.valid && word_hit;
            start = stage.addr - AW'(mwss_pkg::WORD_BYTES - 1);
         end
         mwss_pkg::MODE_STRING: begin
            hit   = stage.valid && string_hit;
            start = stage.addr - (AW'(len_eff) - AW'(1));
         end
         default: begin
            hit   = 1'b0;
            start = stage.addr;
         end
      endcase
   end

   assign page = start & mwss_pkg::PAGE_MASK;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_new_in   = out_new_ff;
      prev_page_in = prev_page_ff;
      if (advance) begin
         out_valid_in = hit;
         if (hit) begin
            out_addr_in  = start;
            out_new_in   = (page != prev_page_ff);
            prev_page_in = page;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         prev_page_ff <= mwss_pkg::PAGE_NONE;
      end else begin
         out_valid_ff <= out_valid_in;
         prev_page_ff <= prev_page_in;
      end
   end

   always_ff @(posedge clock) begin
      out_addr_ff <= out_addr_in;
      out_new_ff  <= out_new_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.match_address = out_addr_ff;
   assign rsp_ch.new_page      = out_new_ff;

endmodule

[design/mwss_checker.sv]
`timescale 1ns / 1ps
`include "masked_word_and_string_search_defines.svh"

module mwss_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [mwss_pkg::ADDR_W-1:0]  rsp_match_address,
   input  logic                         rsp_new_page
);

   logic req_take;

   assign req_take = req_valid && req_ready;

   // a stalled result transaction stays offered
   `MWSS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // and its payload holds
   `MWSS_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_match_address) && $stable(rsp_new_page), "result payload changed while stalled")

   // an empty result register never blocks the input
   `MWSS_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "input stalled with no result pending")

   // no result unless a byte has passed through the window stage to feed it
   `MWSS_ASSERT(a_no_phantom, clock, reset, !rsp_valid && !req_take && !$past(req_take) |=> !rsp_valid, "result without a transaction")

   // reset empties the result register
   `MWSS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind masked_word_and_string_search mwss_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_match_address (rsp_ch.match_address),
   .rsp_new_page      (rsp_ch.new_page)
);
